// ===== rtl/core/swts_pkg.sv =====
// ----------------------------------------------------------------------------
// swts_pkg
// Types and codes shared by the stop-and-wait transfer sender.
// ----------------------------------------------------------------------------
package swts_pkg;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_HELLO = 3'd1,
      PH_WRQ   = 3'd2,
      PH_NEED  = 3'd3,
      PH_DATA  = 3'd4,
      PH_FIN   = 3'd5,
      PH_DONE  = 3'd6,
      PH_FAIL  = 3'd7
   } phase_type;

   // request codes
   localparam logic [2:0] REQ_START     = 3'd0;
   localparam logic [2:0] REQ_CHUNK     = 3'd1;
   localparam logic [2:0] REQ_REPLY     = 3'd2;
   localparam logic [2:0] REQ_TIMEOUT   = 3'd3;
   localparam logic [2:0] REQ_SEND_FAIL = 3'd4;
   localparam logic [2:0] REQ_RECV_FAIL = 3'd5;

   // status codes
   localparam logic [2:0] ST_WAIT    = 3'd0;
   localparam logic [2:0] ST_NEED    = 3'd1;
   localparam logic [2:0] ST_DONE    = 3'd2;
   localparam logic [2:0] ST_RETRY   = 3'd3;
   localparam logic [2:0] ST_SERVER  = 3'd4;
   localparam logic [2:0] ST_LINK    = 3'd5;
   localparam logic [2:0] ST_IGNORED = 3'd6;

   // PDU kinds
   localparam logic [1:0] KIND_HELLO = 2'd0;
   localparam logic [1:0] KIND_WRQ   = 2'd1;
   localparam logic [1:0] KIND_DATA  = 2'd2;
   localparam logic [1:0] KIND_FIN   = 2'd3;

   // register indexes
   localparam logic [1:0] CSR_RETRY_LIMIT = 2'd0;
   localparam logic [1:0] CSR_HELLO_LEN   = 2'd1;
   localparam logic [1:0] CSR_NAME_LEN    = 2'd2;

   localparam int CSR_DATA_W = 9;

   function automatic logic [1:0] kind_of(phase_type ph);
      logic [1:0] k;
      case (ph)
         PH_HELLO: k = KIND_HELLO;
         PH_WRQ:   k = KIND_WRQ;
         PH_DATA:  k = KIND_DATA;
         default:  k = KIND_FIN;
      endcase
      return k;
   endfunction

   function automatic logic seq_of(phase_type ph, logic seq);
      logic s;
      case (ph)
         PH_HELLO: s = 1'b0;
         PH_WRQ:   s = 1'b1;
         default:  s = seq;
      endcase
      return s;
   endfunction

endpackage

// ===== rtl/core/stop_and_wait_transfer_sender.sv =====
// ----------------------------------------------------------------------------
// stop_and_wait_transfer_sender
// Sender side of a four-phase stop-and-wait transfer with retries and
// saturating acknowledge counters.
// ----------------------------------------------------------------------------
//  channel   direction   handshake             contents
//  req_*     in          req_valid/req_ready   one event (start, chunk, reply...)
//  rsp_*     out         rsp_valid/rsp_ready   one result per request
//  csr_*     in          csr_we                retry limit, HELLO/WRQ lengths
//
//  Each request is decoded combinationally; its result is registered and shows
//  on rsp_* the cycle after acceptance. A request is taken every cycle while
//  the result register is empty or being drained, so the rate is one request
//  per clock. rsp_ready low holds the result and stalls req_ready.
//  Reset returns the session to idle and the registers to their defaults.
// ----------------------------------------------------------------------------
module stop_and_wait_transfer_sender #(
   parameter int CHUNK_BYTES_MAX = 512
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_type,
   input  logic [9:0]  req_chunk_length,
   input  logic        req_reply_is_ack,
   input  logic [7:0]  req_reply_seq,
   input  logic        req_reply_has_payload,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_transmit,
   output logic [1:0]  rsp_pdu_kind,
   output logic        rsp_pdu_seq,
   output logic [9:0]  rsp_payload_length,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_chunks_acked,
   output logic [31:0] rsp_bytes_acked,

   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [swts_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam logic [9:0] ChunkCap = 10'(CHUNK_BYTES_MAX);

   logic [7:0]  retry_limit_ff;
   logic [7:0]  hello_len_ff;
   logic [8:0]  name_len_ff;

   swts_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  retry_count_ff, retry_count_in;
   logic        seq_bit_ff, seq_bit_in;
   logic [9:0]  pending_len_ff, pending_len_in;
   logic [15:0] chunk_total_ff, chunk_total_in;
   logic [31:0] byte_total_ff, byte_total_in;

   logic        rsp_valid_ff;
   logic        rsp_transmit_ff, rsp_transmit_in;
   logic [1:0]  rsp_pdu_kind_ff;
   logic        rsp_pdu_seq_ff;
   logic [9:0]  rsp_payload_length_ff;
   logic [2:0]  rsp_status_ff, rsp_status_in;

   logic        req_accept;
   logic        waiting;
   logic        retry;
   logic        seq_match;
   logic [9:0]  clen_cut;
   logic [32:0] byte_sum;

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         retry_limit_ff <= 8'd3;
         hello_len_ff   <= 8'd0;
         name_len_ff    <= 9'd1;
      end else if (csr_we) begin
         case (csr_index)
            swts_pkg::CSR_RETRY_LIMIT: retry_limit_ff <= csr_wdata[7:0];
            swts_pkg::CSR_HELLO_LEN:   hello_len_ff   <= csr_wdata[7:0];
            swts_pkg::CSR_NAME_LEN:    name_len_ff    <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      waiting   = phase_ff inside {swts_pkg::PH_HELLO, swts_pkg::PH_WRQ,
                                   swts_pkg::PH_DATA, swts_pkg::PH_FIN};
      seq_match = req_reply_is_ack &&
                  (req_reply_seq == {7'd0, swts_pkg::seq_of(phase_ff, seq_bit_ff)});
      clen_cut  = ({22'd0, req_chunk_length} > CHUNK_BYTES_MAX) ? ChunkCap
                                                                 : req_chunk_length;
      byte_sum  = {1'b0, byte_total_ff} + {23'd0, pending_len_ff};

      phase_in        = phase_ff;
      retry_count_in  = retry_count_ff;
      seq_bit_in      = seq_bit_ff;
      pending_len_in  = pending_len_ff;
      chunk_total_in  = chunk_total_ff;
      byte_total_in   = byte_total_ff;
      rsp_transmit_in = 1'b0;
      rsp_status_in   = swts_pkg::ST_IGNORED;
      retry           = 1'b0;

      case (req_type)
         swts_pkg::REQ_START: begin
            if (phase_ff inside {swts_pkg::PH_IDLE, swts_pkg::PH_DONE,
                                 swts_pkg::PH_FAIL}) begin
               chunk_total_in  = 16'd0;
               byte_total_in   = 32'd0;
               seq_bit_in      = 1'b0;
               phase_in        = swts_pkg::PH_HELLO;
               pending_len_in  = {2'd0, hello_len_ff};
               retry_count_in  = 8'd1;
               rsp_transmit_in = 1'b1;
               rsp_status_in   = swts_pkg::ST_WAIT;
            end
         end
         swts_pkg::REQ_CHUNK: begin
            if (phase_ff == swts_pkg::PH_NEED) begin
               if (req_chunk_length == 10'd0) begin
                  phase_in       = swts_pkg::PH_FIN;
                  pending_len_in = 10'd0;
               end else begin
                  phase_in       = swts_pkg::PH_DATA;
                  pending_len_in = clen_cut;
               end
               retry_count_in  = 8'd1;
               rsp_transmit_in = 1'b1;
               rsp_status_in   = swts_pkg::ST_WAIT;
            end
         end
         swts_pkg::REQ_REPLY: begin
            if (waiting) begin
               if (!seq_match) begin
                  retry = 1'b1;
               end else if (phase_ff == swts_pkg::PH_HELLO ||
                            phase_ff == swts_pkg::PH_WRQ) begin
                  if (req_reply_has_payload) begin
                     phase_in      = swts_pkg::PH_FAIL;
                     rsp_status_in = swts_pkg::ST_SERVER;
                  end else if (phase_ff == swts_pkg::PH_HELLO) begin
                     phase_in        = swts_pkg::PH_WRQ;
                     pending_len_in  = {1'b0, name_len_ff};
                     retry_count_in  = 8'd1;
                     rsp_transmit_in = 1'b1;
                     rsp_status_in   = swts_pkg::ST_WAIT;
                  end else begin
                     seq_bit_in    = 1'b0;
                     phase_in      = swts_pkg::PH_NEED;
                     rsp_status_in = swts_pkg::ST_NEED;
                  end
               end else if (phase_ff == swts_pkg::PH_DATA) begin
                  if (chunk_total_ff != 16'hFFFF) begin
                     chunk_total_in = chunk_total_ff + 16'd1;
                  end
                  byte_total_in = byte_sum[32] ? 32'hFFFF_FFFF : byte_sum[31:0];
                  seq_bit_in    = !seq_bit_ff;
                  phase_in      = swts_pkg::PH_NEED;
                  rsp_status_in = swts_pkg::ST_NEED;
               end else begin
                  phase_in      = swts_pkg::PH_DONE;
                  rsp_status_in = swts_pkg::ST_DONE;
               end
            end
         end
         swts_pkg::REQ_TIMEOUT: begin
            retry = waiting;
         end
         swts_pkg::REQ_SEND_FAIL: begin
            if (waiting) begin
               phase_in      = swts_pkg::PH_FAIL;
               rsp_status_in = swts_pkg::ST_LINK;
            end
         end
         swts_pkg::REQ_RECV_FAIL: begin
            if (phase_ff == swts_pkg::PH_DATA || phase_ff == swts_pkg::PH_FIN) begin
               retry = 1'b1;
            end else if (waiting) begin
               phase_in      = swts_pkg::PH_FAIL;
               rsp_status_in = swts_pkg::ST_LINK;
            end
         end
         default: ;
      endcase

      if (retry) begin
         if (retry_count_ff >= retry_limit_ff) begin
            phase_in      = swts_pkg::PH_FAIL;
            rsp_status_in = swts_pkg::ST_RETRY;
         end else begin
            retry_count_in  = retry_count_ff + 8'd1;
            rsp_transmit_in = 1'b1;
            rsp_status_in   = swts_pkg::ST_WAIT;
         end
      end
   end

   // session state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= swts_pkg::PH_IDLE;
         retry_count_ff <= 8'd0;
         seq_bit_ff     <= 1'b0;
         pending_len_ff <= 10'd0;
         chunk_total_ff <= 16'd0;
         byte_total_ff  <= 32'd0;
      end else if (req_accept) begin
         phase_ff       <= phase_in;
         retry_count_ff <= retry_count_in;
         seq_bit_ff     <= seq_bit_in;
         pending_len_ff <= pending_len_in;
         chunk_total_ff <= chunk_total_in;
         byte_total_ff  <= byte_total_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_transmit_ff       <= rsp_transmit_in;
         rsp_pdu_kind_ff       <= rsp_transmit_in ? swts_pkg::kind_of(phase_in) : 2'd0;
         rsp_pdu_seq_ff        <= rsp_transmit_in &&
                                  swts_pkg::seq_of(phase_in, seq_bit_in);
         rsp_payload_length_ff <= rsp_transmit_in ? pending_len_in : 10'd0;
         rsp_status_ff         <= rsp_status_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_transmit       = rsp_transmit_ff;
   assign rsp_pdu_kind       = rsp_pdu_kind_ff;
   assign rsp_pdu_seq        = rsp_pdu_seq_ff;
   assign rsp_payload_length = rsp_payload_length_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_chunks_acked   = chunk_total_ff;
   assign rsp_bytes_acked    = byte_total_ff;

   a_no_tx_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_transmit_ff) |->
         (rsp_pdu_kind_ff == 2'd0 && !rsp_pdu_seq_ff && rsp_payload_length_ff == 10'd0))
      else $error("fields not cleared without transmit");

   a_counters_monotonic: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_type != swts_pkg::REQ_START) |=>
         (chunk_total_ff >= $past(chunk_total_ff) && byte_total_ff >= $past(byte_total_ff)))
      else $error("acknowledge counter decreased");

   a_fail_status_phase: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> ((rsp_status_ff != swts_pkg::ST_RETRY &&
                       rsp_status_ff != swts_pkg::ST_LINK &&
                       rsp_status_ff != swts_pkg::ST_SERVER) ||
                      phase_ff == swts_pkg::PH_FAIL))
      else $error("failure status without failed session");

   a_hello_seq_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_transmit_ff && rsp_pdu_kind_ff == swts_pkg::KIND_HELLO) |->
         !rsp_pdu_seq_ff)
      else $error("HELLO sent with sequence one");

endmodule

// ===== test/stop_and_wait_transfer_sender_tb.sv =====
// ----------------------------------------------------------------------------
// stop_and_wait_transfer_sender_tb
// Drives sessions of requests into the stop-and-wait sender: directed corner
// cases first, then mostly well-formed random sessions mixed with noise, under
// several register settings. Every response is checked against a cycle-free
// predictor kept in a small scoreboard class.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stop_and_wait_transfer_sender_tb;

   localparam int CHUNK_MAX = 512;
   localparam logic [2:0] REQ_UNUSED6 = 3'd6;
   localparam logic [2:0] REQ_UNUSED7 = 3'd7;
   localparam logic [1:0] CSR_UNUSED  = 2'd3;

   typedef struct packed {
      logic [2:0] kind;
      logic [9:0] chunk_len;
      logic       is_ack;
      logic [7:0] seq;
      logic       has_payload;
   } request_type;

   typedef struct packed {
      logic        transmit;
      logic [1:0]  pdu_kind;
      logic        pdu_seq;
      logic [9:0]  length;
      logic [2:0]  status;
      logic [15:0] chunks;
      logic [31:0] bytes;
   } result_type;

   class transfer_scoreboard;
      int unsigned chunk_max;
      logic [7:0]  retry_limit;
      logic [7:0]  hello_len;
      logic [8:0]  name_len;
      swts_pkg::phase_type phase;
      logic [7:0]  sends;
      logic        seq_bit;
      logic [9:0]  pending_len;
      logic [15:0] chunk_total;
      logic [31:0] byte_total;
      result_type  expected_q[$];
      int          errors;
      int          requests;
      int          useful;
      int          responses;
      int          resends;
      int          status_seen[8];

      function new(int unsigned max_len);
         chunk_max   = max_len;
         retry_limit = 8'd3;
         hello_len   = 8'd0;
         name_len    = 9'd1;
         phase       = swts_pkg::PH_IDLE;
         sends       = '0;
         seq_bit     = 1'b0;
         pending_len = '0;
         chunk_total = '0;
         byte_total  = '0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [8:0] data);
         case (idx)
            swts_pkg::CSR_RETRY_LIMIT: retry_limit = data[7:0];
            swts_pkg::CSR_HELLO_LEN:   hello_len = data[7:0];
            swts_pkg::CSR_NAME_LEN:    name_len = data;
            default: ;
         endcase
      endfunction

      function logic wanted_seq();
         if (phase == swts_pkg::PH_HELLO) return 1'b0;
         if (phase == swts_pkg::PH_WRQ) return 1'b1;
         return seq_bit;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void note_request(request_type r);
         logic        tx;
         logic        retry;
         logic        waiting;
         logic [2:0]  st;
         logic [32:0] sum;
         result_type  e;
         tx = 1'b0;
         retry = 1'b0;
         st = swts_pkg::ST_IGNORED;
         waiting = phase inside {swts_pkg::PH_HELLO, swts_pkg::PH_WRQ,
                                 swts_pkg::PH_DATA, swts_pkg::PH_FIN};
         case (r.kind)
            swts_pkg::REQ_START: begin
               if (phase inside {swts_pkg::PH_IDLE, swts_pkg::PH_DONE,
                                 swts_pkg::PH_FAIL}) begin
                  chunk_total = '0;
                  byte_total = '0;
                  seq_bit = 1'b0;
                  phase = swts_pkg::PH_HELLO;
                  pending_len = {2'b00, hello_len};
                  sends = 8'd1;
                  tx = 1'b1;
                  st = swts_pkg::ST_WAIT;
               end
            end
            swts_pkg::REQ_CHUNK: begin
               if (phase == swts_pkg::PH_NEED) begin
                  if (r.chunk_len == '0) begin
                     phase = swts_pkg::PH_FIN;
                     pending_len = '0;
                  end else begin
                     phase = swts_pkg::PH_DATA;
                     pending_len = (r.chunk_len > chunk_max) ? 10'(chunk_max) : r.chunk_len;
                  end
                  sends = 8'd1;
                  tx = 1'b1;
                  st = swts_pkg::ST_WAIT;
               end
            end
            swts_pkg::REQ_REPLY: begin
               if (waiting) begin
                  if (!(r.is_ack && r.seq == {7'b0, wanted_seq()})) begin
                     retry = 1'b1;
                  end else if (phase inside {swts_pkg::PH_HELLO, swts_pkg::PH_WRQ}) begin
                     if (r.has_payload) begin
                        phase = swts_pkg::PH_FAIL;
                        st = swts_pkg::ST_SERVER;
                     end else if (phase == swts_pkg::PH_HELLO) begin
                        phase = swts_pkg::PH_WRQ;
                        pending_len = {1'b0, name_len};
                        sends = 8'd1;
                        tx = 1'b1;
                        st = swts_pkg::ST_WAIT;
                     end else begin
                        seq_bit = 1'b0;
                        phase = swts_pkg::PH_NEED;
                        st = swts_pkg::ST_NEED;
                     end
                  end else if (phase == swts_pkg::PH_DATA) begin
                     if (chunk_total != 16'hFFFF) chunk_total++;
                     sum = {1'b0, byte_total} + {23'b0, pending_len};
                     byte_total = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                     seq_bit = ~seq_bit;
                     phase = swts_pkg::PH_NEED;
                     st = swts_pkg::ST_NEED;
                  end else begin
                     phase = swts_pkg::PH_DONE;
                     st = swts_pkg::ST_DONE;
                  end
               end
            end
            swts_pkg::REQ_TIMEOUT: retry = waiting;
            swts_pkg::REQ_SEND_FAIL: begin
               if (waiting) begin
                  phase = swts_pkg::PH_FAIL;
                  st = swts_pkg::ST_LINK;
               end
            end
            swts_pkg::REQ_RECV_FAIL: begin
               if (phase inside {swts_pkg::PH_DATA, swts_pkg::PH_FIN}) begin
                  retry = 1'b1;
               end else if (waiting) begin
                  phase = swts_pkg::PH_FAIL;
                  st = swts_pkg::ST_LINK;
               end
            end
            default: ;
         endcase
         if (retry) begin
            if (sends >= retry_limit) begin
               phase = swts_pkg::PH_FAIL;
               st = swts_pkg::ST_RETRY;
            end else begin
               sends++;
               tx = 1'b1;
               st = swts_pkg::ST_WAIT;
               resends++;
            end
         end
         e = '0;
         e.transmit = tx;
         if (tx) begin
            case (phase)
               swts_pkg::PH_HELLO: e.pdu_kind = swts_pkg::KIND_HELLO;
               swts_pkg::PH_WRQ:   e.pdu_kind = swts_pkg::KIND_WRQ;
               swts_pkg::PH_DATA:  e.pdu_kind = swts_pkg::KIND_DATA;
               default:            e.pdu_kind = swts_pkg::KIND_FIN;
            endcase
            e.pdu_seq = wanted_seq();
            e.length = pending_len;
         end
         e.status = st;
         e.chunks = chunk_total;
         e.bytes = byte_total;
         expected_q.push_back(e);
         requests++;
         if (st != swts_pkg::ST_IGNORED) useful++;
         if (r.kind == swts_pkg::REQ_START && st == swts_pkg::ST_WAIT) status_seen[7]++;
         status_seen[st]++;
      endfunction

      task report(string msg);
         errors++;
         $display("%0t ERROR: %s", $time, msg);
      endtask

      task field_check(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want)
            report($sformatf("response %0d %s: got %0h, expected %0h",
                             responses, name, got, want));
      endtask

      task check_response(result_type got);
         result_type e;
         if (expected_q.size() == 0) begin
            report("response with no request outstanding");
         end else begin
            e = expected_q.pop_front();
            field_check("transmit", 32'(got.transmit), 32'(e.transmit));
            field_check("pdu_kind", 32'(got.pdu_kind), 32'(e.pdu_kind));
            field_check("pdu_seq", 32'(got.pdu_seq), 32'(e.pdu_seq));
            field_check("payload_length", 32'(got.length), 32'(e.length));
            field_check("status", 32'(got.status), 32'(e.status));
            field_check("chunks_acked", 32'(got.chunks), 32'(e.chunks));
            field_check("bytes_acked", got.bytes, e.bytes);
         end
         responses++;
      endtask

      task close_out();
         while (expected_q.size() != 0) begin
            void'(expected_q.pop_front());
            report("expected response never arrived");
         end
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_type = '0;
   logic [9:0]  req_chunk_length = '0;
   logic        req_reply_is_ack = 1'b0;
   logic [7:0]  req_reply_seq = '0;
   logic        req_reply_has_payload = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_transmit;
   logic [1:0]  rsp_pdu_kind;
   logic        rsp_pdu_seq;
   logic [9:0]  rsp_payload_length;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_chunks_acked;
   logic [31:0] rsp_bytes_acked;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [swts_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   transfer_scoreboard sb;
   bit req_gaps_on = 1'b1;
   bit rsp_stalls_on = 1'b1;
   int stall_left = 0;

   stop_and_wait_transfer_sender #(.CHUNK_BYTES_MAX(CHUNK_MAX)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
      .req_chunk_length(req_chunk_length), .req_reply_is_ack(req_reply_is_ack),
      .req_reply_seq(req_reply_seq), .req_reply_has_payload(req_reply_has_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_transmit(rsp_transmit),
      .rsp_pdu_kind(rsp_pdu_kind), .rsp_pdu_seq(rsp_pdu_seq),
      .rsp_payload_length(rsp_payload_length), .rsp_status(rsp_status),
      .rsp_chunks_acked(rsp_chunks_acked), .rsp_bytes_acked(rsp_bytes_acked),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("FAILURE");
      $finish;
   end

   function automatic int idle_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 60) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // result side: random back-pressure
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left = stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (rsp_stalls_on && $urandom_range(0, 3) == 0 && idle_len() != 0) begin
         stall_left = idle_len();
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      result_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.transmit = rsp_transmit;
         got.pdu_kind = rsp_pdu_kind;
         got.pdu_seq = rsp_pdu_seq;
         got.length = rsp_payload_length;
         got.status = rsp_status;
         got.chunks = rsp_chunks_acked;
         got.bytes = rsp_bytes_acked;
         sb.check_response(got);
      end
   end

   function automatic request_type make_request(logic [2:0] kind, logic [9:0] len,
                                                logic ack, logic [7:0] seq, logic pl);
      request_type r;
      r.kind = kind;
      r.chunk_len = len;
      r.is_ack = ack;
      r.seq = seq;
      r.has_payload = pl;
      return r;
   endfunction

   function automatic request_type noise_request();
      return make_request(3'($urandom), 10'($urandom), 1'($urandom),
                          8'($urandom), 1'($urandom));
   endfunction

   function automatic request_type session_request();
      request_type r;
      int p;
      r = noise_request();
      p = $urandom_range(0, 99);
      case (sb.phase)
         swts_pkg::PH_IDLE, swts_pkg::PH_DONE, swts_pkg::PH_FAIL:
            r.kind = swts_pkg::REQ_START;
         swts_pkg::PH_NEED: begin
            r.kind = swts_pkg::REQ_CHUNK;
            if (p < 12) r.chunk_len = '0;
            else if (p < 17) r.chunk_len = 10'($urandom_range(CHUNK_MAX + 1, 1023));
            else if (p < 25) r.chunk_len = 10'(CHUNK_MAX);
            else r.chunk_len = 10'($urandom_range(1, CHUNK_MAX - 1));
         end
         default: begin
            if (p < 70) begin
               r.kind = swts_pkg::REQ_REPLY;
               r.is_ack = 1'b1;
               r.seq = {7'b0, sb.wanted_seq()};
               if (sb.phase inside {swts_pkg::PH_HELLO, swts_pkg::PH_WRQ})
                  r.has_payload = ($urandom_range(0, 39) == 0);
            end else if (p < 78) begin
               r.kind = swts_pkg::REQ_REPLY;
               case ($urandom_range(0, 2))
                  0: begin
                     r.is_ack = 1'b0;
                     r.seq = {7'b0, sb.wanted_seq()};
                  end
                  1: begin
                     r.is_ack = 1'b1;
                     r.seq = {7'b0, ~sb.wanted_seq()};
                  end
                  default: begin
                     r.is_ack = 1'b1;
                     r.seq = 8'($urandom_range(2, 255));
                  end
               endcase
            end else if (p < 88) begin
               r.kind = swts_pkg::REQ_TIMEOUT;
            end else if (p < 95) begin
               r.kind = swts_pkg::REQ_RECV_FAIL;
            end else begin
               r.kind = swts_pkg::REQ_SEND_FAIL;
            end
         end
      endcase
      return r;
   endfunction

   // one request: optional gap, then hold valid until accepted
   task send_request(request_type r);
      int gap;
      gap = req_gaps_on ? idle_len() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= r.kind;
      req_chunk_length <= r.chunk_len;
      req_reply_is_ack <= r.is_ack;
      req_reply_seq <= r.seq;
      req_reply_has_payload <= r.has_payload;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(r);
   endtask

   task wait_idle();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
         guard++;
      end while (sb.pending() != 0 && guard < 100000);
   endtask

   task csr_write(logic [1:0] idx, logic [swts_pkg::CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.write_reg(idx, data);
   endtask

   task configure(logic [8:0] retry, logic [8:0] cred, logic [8:0] name);
      wait_idle();
      csr_write(swts_pkg::CSR_RETRY_LIMIT, retry);
      csr_write(swts_pkg::CSR_HELLO_LEN, cred);
      csr_write(swts_pkg::CSR_NAME_LEN, name);
      csr_write(CSR_UNUSED, 9'($urandom));
      csr_we <= 1'b0;
   endtask

   task random_part(int count);
      int goal;
      int n;
      goal = sb.useful + count;
      n = 0;
      while (sb.useful < goal) begin
         if (n % 150 == 0) begin
            req_gaps_on = ($urandom_range(0, 3) != 0);
            rsp_stalls_on = ($urandom_range(0, 3) != 0);
         end
         n++;
         if ($urandom_range(0, 99) < 8) send_request(noise_request());
         else send_request(session_request());
      end
   endtask

   task directed_part();
      send_request(make_request(swts_pkg::REQ_TIMEOUT, '0, 1'b0, '0, 1'b0));
      send_request(make_request(REQ_UNUSED7, 10'h3FF, 1'b1, 8'hFF, 1'b1));
      send_request(make_request(swts_pkg::REQ_CHUNK, 10'd10, 1'b0, '0, 1'b0));
      send_request(make_request(swts_pkg::REQ_START, '0, 1'b0, '0, 1'b0));
      send_request(make_request(swts_pkg::REQ_START, '0, 1'b0, '0, 1'b0));
      send_request(make_request(swts_pkg::REQ_REPLY, '0, 1'b1, 8'd1, 1'b0));
      send_request(make_request(swts_pkg::REQ_REPLY, '0, 1'b0, 8'd0, 1'b0));
      send_request(make_request(swts_pkg::REQ_REPLY, '0, 1'b1, 8'd0, 1'b0));
      send_request(make_request(swts_pkg::REQ_REPLY, '0, 1'b1, 8'hFF, 1'b0));
      send_request(make_request(swts_pkg::REQ_REPLY, '0, 1'b1, 8'd1, 1'b0));
      // oversized chunk is cut to the maximum
      send_request(make_request(swts_pkg::REQ_CHUNK, 10'h3FF, 1'b0, '0, 1'b0));
      send_request(make_request(swts_pkg::REQ_RECV_FAIL, '0, 1'b0, '0, 1'b0));
      // payload on a data ack still counts
      send_request(make_request(swts_pkg::REQ_REPLY, '0, 1'b1, 8'd0, 1'b1));
      send_request(make_request(swts_pkg::REQ_CHUNK, 10'd1, 1'b0, '0, 1'b0));
      repeat (3) send_request(make_request(swts_pkg::REQ_TIMEOUT, '0, 1'b0, '0, 1'b0));
      send_request(make_request(swts_pkg::REQ_START, '0, 1'b0, '0, 1'b0));
      send_request(make_request(swts_pkg::REQ_REPLY, '0, 1'b1, 8'd0, 1'b1));
      send_request(make_request(swts_pkg::REQ_START, '0, 1'b0, '0, 1'b0));
      send_request(make_request(swts_pkg::REQ_SEND_FAIL, '0, 1'b0, '0, 1'b0));
      send_request(make_request(swts_pkg::REQ_START, '0, 1'b0, '0, 1'b0));
      send_request(make_request(swts_pkg::REQ_RECV_FAIL, '0, 1'b0, '0, 1'b0));
      send_request(make_request(swts_pkg::REQ_START, '0, 1'b0, '0, 1'b0));
      send_request(make_request(swts_pkg::REQ_REPLY, '0, 1'b1, 8'd0, 1'b0));
      send_request(make_request(swts_pkg::REQ_REPLY, '0, 1'b1, 8'd1, 1'b0));
      send_request(make_request(swts_pkg::REQ_CHUNK, 10'd0, 1'b0, '0, 1'b0));
      send_request(make_request(swts_pkg::REQ_REPLY, '0, 1'b1, 8'd0, 1'b0));
      send_request(make_request(REQ_UNUSED6, '0, 1'b0, '0, 1'b0));
   endtask

   initial begin
      sb = new(CHUNK_MAX);
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed_part();

      configure(9'd1, 9'd255, 9'd256);
      random_part(350);

      configure(9'h1FF, 9'd0, 9'd511);
      send_request(make_request(swts_pkg::REQ_START, '0, 1'b0, '0, 1'b0));
      while (sb.phase == swts_pkg::PH_HELLO)
         send_request(make_request(swts_pkg::REQ_TIMEOUT, '0, 1'b0, '0, 1'b0));
      random_part(350);

      // retry limit zero acts as one
      configure(9'h100, 9'h080, 9'd0);
      random_part(150);

      configure({1'($urandom), 8'($urandom_range(2, 8))}, 9'($urandom),
                9'($urandom_range(1, 256)));
      random_part(550);

      wait_idle();
      repeat (5) @(posedge clock);
      sb.close_out();
      $display("covered %0d requests (%0d ignored) in %0d sessions: %0d done, %0d out of retries,",
               sb.requests, sb.status_seen[swts_pkg::ST_IGNORED], sb.status_seen[7],
               sb.status_seen[swts_pkg::ST_DONE], sb.status_seen[swts_pkg::ST_RETRY]);
      $display("%0d server errors, %0d link errors, %0d resends, final chunk count %0d",
               sb.status_seen[swts_pkg::ST_SERVER], sb.status_seen[swts_pkg::ST_LINK],
               sb.resends, sb.chunk_total);
      if (sb.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
